// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent after the delay given by dly
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("delayed check failed");

// expression never true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// File: src/cte_pkg.sv
// Shared widths, constants, types and month table for the epoch converter.
`timescale 1ns / 1ps
package cte_pkg;

  localparam int YEAR_W  = 10;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int EPOCH_W = 35;

  localparam int FYEAR_W = 12;
  localparam int YDAYS_W = 19;
  localparam int MDAYS_W = 9;
  localparam int DAYS_W  = 20;
  localparam int TOD_W   = 17;
  localparam int PROD_W  = 23;

  localparam int YEAR_BASE      = 1900;
  localparam int EPOCH_YEAR_OFS = 70;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int CENTURY        = 100;
  localparam int LEAPS_TO_1969  = 477;
  localparam int RECIP100       = 1311;
  localparam int RECIP_SHIFT    = 17;
  localparam int MONTH_CLAMP    = 12;
  localparam int MONTH_MAR      = 2;
  localparam int SEC_PER_MIN    = 60;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int SEC_PER_DAY    = 86400;

  typedef struct packed {
    logic                valid;
    logic [DAYS_W-1:0]   days;
    logic [TOD_W-1:0]    tod;
  } days_xfer_t;

  function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] mon);
    logic [MDAYS_W-1:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// File: src/cte_days.sv
// Three-stage day count: leap counts, year and month days, then day total.
`timescale 1ns / 1ps
module cte_days (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [cte_pkg::YEAR_W-1:0]    year,
  input  logic [cte_pkg::MONTH_W-1:0]   month,
  input  logic [cte_pkg::DAY_W-1:0]     day,
  input  logic [cte_pkg::HOUR_W-1:0]    hour,
  input  logic [cte_pkg::MIN_W-1:0]     minute,
  input  logic [cte_pkg::SEC_W-1:0]     second,
  output cte_pkg::days_xfer_t           xfer
);
  import cte_pkg::*;

  // stage 1
  logic                 s1_valid_r;
  logic [YEAR_W-1:0]    s1_yr_r;
  logic [9:0]           s1_n4_r;
  logic [4:0]           s1_q100n_r;
  logic [2:0]           s1_q400n_r;
  logic [FYEAR_W-1:0]   s1_fy_r;
  logic [4:0]           s1_q100f_r;
  logic [MONTH_W-1:0]   s1_mon_r;
  logic [DAY_W-1:0]     s1_day_r;
  logic [TOD_W-1:0]     s1_tod_r;

  logic [FYEAR_W-1:0]   fy_nxt;
  logic [FYEAR_W-1:0]   n_nxt;
  logic [PROD_W-1:0]    prod_n;
  logic [PROD_W-1:0]    prod_n4;
  logic [PROD_W-1:0]    prod_f;
  logic [MONTH_W-1:0]   mon_nxt;
  logic [TOD_W-1:0]     tod_nxt;

  always_comb begin
    fy_nxt  = FYEAR_W'(YEAR_BASE) + FYEAR_W'(year);
    n_nxt   = fy_nxt - FYEAR_W'(1);
    prod_n  = PROD_W'(n_nxt) * PROD_W'(RECIP100);
    prod_n4 = PROD_W'(n_nxt[FYEAR_W-1:2]) * PROD_W'(RECIP100);
    prod_f  = PROD_W'(fy_nxt) * PROD_W'(RECIP100);
    mon_nxt = (month > MONTH_W'(MONTH_CLAMP)) ? MONTH_W'(MONTH_CLAMP) : month;
    tod_nxt = TOD_W'(hour) * TOD_W'(SEC_PER_HOUR) + TOD_W'(minute) * TOD_W'(SEC_PER_MIN)
            + TOD_W'(second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_yr_r    <= year;
    s1_n4_r    <= n_nxt[FYEAR_W-1:2];
    s1_q100n_r <= 5'(prod_n >> RECIP_SHIFT);
    s1_q400n_r <= 3'(prod_n4 >> RECIP_SHIFT);
    s1_fy_r    <= fy_nxt;
    s1_q100f_r <= 5'(prod_f >> RECIP_SHIFT);
    s1_mon_r   <= mon_nxt;
    s1_day_r   <= day;
    s1_tod_r   <= tod_nxt;
  end

  // stage 2
  logic                 s2_valid_r;
  logic [YDAYS_W-1:0]   s2_ydays_r;
  logic [MDAYS_W-1:0]   s2_mdays_r;
  logic [DAY_W-1:0]     s2_day_r;
  logic [TOD_W-1:0]     s2_tod_r;

  logic [9:0]           nleap;
  logic [YEAR_W-1:0]    yoff;
  logic [YDAYS_W-1:0]   ydays_nxt;
  logic [FYEAR_W-1:0]   rem100;
  logic                 leap;
  logic [MDAYS_W-1:0]   mdays_nxt;

  always_comb begin
    nleap  = s1_n4_r - 10'(s1_q100n_r) + 10'(s1_q400n_r) - 10'(LEAPS_TO_1969);
    yoff   = s1_yr_r - YEAR_W'(EPOCH_YEAR_OFS);
    if (s1_yr_r > YEAR_W'(EPOCH_YEAR_OFS)) begin
      ydays_nxt = YDAYS_W'(yoff) * YDAYS_W'(DAYS_PER_YEAR) + YDAYS_W'(nleap[7:0]);
    end else begin
      ydays_nxt = '0;
    end
    rem100 = s1_fy_r - FYEAR_W'(s1_q100f_r) * FYEAR_W'(CENTURY);
    leap   = (s1_fy_r[1:0] == 2'b00) && ((rem100 != '0) || (s1_q100f_r[1:0] == 2'b00));
    mdays_nxt = days_before_month(s1_mon_r)
              + MDAYS_W'(leap && (s1_mon_r >= MONTH_W'(MONTH_MAR)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_ydays_r <= ydays_nxt;
    s2_mdays_r <= mdays_nxt;
    s2_day_r   <= s1_day_r;
    s2_tod_r   <= s1_tod_r;
  end

  // stage 3: day total, may be minus one for day zero
  logic                 s3_valid_r;
  logic [DAYS_W-1:0]    s3_days_r;
  logic [TOD_W-1:0]     s3_tod_r;
  logic [DAYS_W-1:0]    days_nxt;

  assign days_nxt = DAYS_W'(s2_ydays_r) + DAYS_W'(s2_mdays_r) + DAYS_W'(s2_day_r)
                  - DAYS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_days_r <= days_nxt;
    s3_tod_r  <= s2_tod_r;
  end

  assign xfer.valid = s3_valid_r;
  assign xfer.days  = s3_days_r;
  assign xfer.tod   = s3_tod_r;

endmodule

// File: src/cte_scale.sv
// Two-stage scaling of the day count to seconds and the output register.
`timescale 1ns / 1ps
module cte_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cte_pkg::days_xfer_t           xfer,
  output logic                          out_valid,
  output logic [cte_pkg::EPOCH_W-1:0]   epoch_seconds
);
  import cte_pkg::*;

  localparam int MUL_W = DAYS_W + 18;

  logic                 s4_valid_r;
  logic [EPOCH_W-1:0]   s4_dsec_r;
  logic [TOD_W-1:0]     s4_tod_r;
  logic signed [MUL_W-1:0] dsec_full;

  logic                 out_valid_r;
  logic [EPOCH_W-1:0]   out_sec_r;

  assign dsec_full = MUL_W'($signed(xfer.days)) * MUL_W'(SEC_PER_DAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s4_valid_r  <= xfer.valid;
      out_valid_r <= s4_valid_r;
    end
    s4_dsec_r <= dsec_full[EPOCH_W-1:0];
    s4_tod_r  <= xfer.tod;
    out_sec_r <= s4_dsec_r + EPOCH_W'(s4_tod_r);
  end

  assign out_valid     = out_valid_r;
  assign epoch_seconds = out_sec_r;

endmodule

// File: src/calendar_to_epoch_seconds.sv
// Top level of the UTC calendar to epoch seconds converter.
`timescale 1ns / 1ps
// Converts a UTC broken-down time (year since 1900, month 0..11, day,
// hour, minute, second with 60 for a leap second) to seconds since
// 1970-01-01 00:00:00. A transaction is taken at each clock edge with
// start high and busy low; busy is high only while rst_n is low, so one
// transaction can enter every cycle. The result passes through the five
// register stages of the pipeline (leap counts, year and month days, day
// total, day scaling and the final add) and appears for exactly one cycle
// with out_valid high, in input order; the receiver must take it then.
module calendar_to_epoch_seconds (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cte_pkg::YEAR_W-1:0]    in_year_since_1900,
  input  logic [cte_pkg::MONTH_W-1:0]   in_month_index,
  input  logic [cte_pkg::DAY_W-1:0]     in_day_of_month,
  input  logic [cte_pkg::HOUR_W-1:0]    in_hour_of_day,
  input  logic [cte_pkg::MIN_W-1:0]     in_minute_of_hour,
  input  logic [cte_pkg::SEC_W-1:0]     in_second_of_minute,
  output logic                          out_valid,
  output logic [cte_pkg::EPOCH_W-1:0]   out_epoch_seconds
);
  import cte_pkg::*;

  days_xfer_t days_xfer;
  logic       in_accept;

  assign busy      = ~rst_n;
  assign in_accept = start & ~busy;

  cte_days u_cte_days (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .year     (in_year_since_1900),
    .month    (in_month_index),
    .day      (in_day_of_month),
    .hour     (in_hour_of_day),
    .minute   (in_minute_of_hour),
    .second   (in_second_of_minute),
    .xfer     (days_xfer)
  );

  cte_scale u_cte_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .xfer          (days_xfer),
    .out_valid     (out_valid),
    .epoch_seconds (out_epoch_seconds)
  );

endmodule

// File: src/cte_checker.sv
// Port-level checker for the epoch converter and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cte_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [cte_pkg::YEAR_W-1:0]    in_year_since_1900,
  input  logic [cte_pkg::MONTH_W-1:0]   in_month_index,
  input  logic [cte_pkg::DAY_W-1:0]     in_day_of_month,
  input  logic [cte_pkg::HOUR_W-1:0]    in_hour_of_day,
  input  logic [cte_pkg::MIN_W-1:0]     in_minute_of_hour,
  input  logic [cte_pkg::SEC_W-1:0]     in_second_of_minute,
  input  logic                          out_valid,
  input  logic [cte_pkg::EPOCH_W-1:0]   out_epoch_seconds
);
  import cte_pkg::*;

  `ASSERT_NEVER(busy_only_in_reset, clk, rst_n, busy)

  `ASSERT_DELAYED(result_follows_transaction, clk, rst_n, start && !busy, 5, out_valid)

  `ASSERT_IMPLIES(result_has_transaction, clk, rst_n, out_valid, $past(start && !busy, 5))

  `ASSERT_IMPLIES(first_day_seconds, clk, rst_n, out_valid && $past(in_year_since_1900 == 10'd70 && in_month_index == 4'd0 && in_day_of_month == 5'd1 && in_hour_of_day == 5'd0, 5), out_epoch_seconds == EPOCH_W'($past(in_minute_of_hour, 5)) * EPOCH_W'(SEC_PER_MIN) + EPOCH_W'($past(in_second_of_minute, 5)))

endmodule

bind calendar_to_epoch_seconds cte_checker u_cte_checker (.*);
